// ===== sv/mrma_pkg.sv =====
// Shared types, widths and codes of the marker region moment accumulator.
package mrma_pkg;

  // Default number of regions in each of the two rows.
  localparam int REGIONS_PER_ROW_DEF = 9;

  // Field widths.
  localparam int COORD_BITS = 11;
  localparam int PIX_W      = 8;
  localparam int IDX_W      = 5;
  localparam int CNT_W      = 23;
  localparam int XY_W       = 33;
  localparam int IS_W       = 30;
  localparam int LOW_W      = COORD_BITS + 1;

  // Configuration port widths.
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Configuration reset values.
  localparam logic [PIX_W-1:0]      THRESHOLD_RST = 8'd10;
  localparam logic [COORD_BITS-1:0] SEPARATOR_RST = 11'd380;
  localparam logic [LOW_W-1:0]      FRAME_RST     = 12'd2048;

  // Request codes of an input word.
  typedef enum logic [1:0] {
    REQ_PIXEL  = 2'd0,
    REQ_MARGIN = 2'd1,
    REQ_READ   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_SEPARATOR = 2'd1,
    CFG_FRAME_W   = 2'd2,
    CFG_FRAME_H   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0]      threshold;
    logic [COORD_BITS-1:0] separator;
    logic [LOW_W-1:0]      frame_width;
    logic [LOW_W-1:0]      frame_height;
  } cfg_t;

  // A word as it travels along the chain of cells.
  typedef struct packed {
    logic                  valid;
    req_t                  req;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [PIX_W-1:0]      pix;
    logic                  keep;
    logic                  first_row;
    logic                  done;
    logic [IDX_W-1:0]      midx;
    logic [COORD_BITS-1:0] mval;
  } item_t;

  // Statistics of one region.
  typedef struct packed {
    logic [CNT_W-1:0]      cnt;
    logic [XY_W-1:0]       xsum;
    logic [XY_W-1:0]       ysum;
    logic [IS_W-1:0]       isum;
    logic [PIX_W-1:0]      peak;
    logic [LOW_W-1:0]      xlo;
    logic [COORD_BITS-1:0] xhi;
    logic [LOW_W-1:0]      ylo;
    logic [COORD_BITS-1:0] yhi;
  } stat_t;

  // One result word.
  typedef struct packed {
    logic [IDX_W-1:0] region;
    stat_t            st;
    logic             last;
  } out_word_t;

endpackage

// ===== sv/mrma_if.sv =====
// Stream interfaces of the request input and the result output.
interface mrma_in_if;
  import mrma_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [1:0]            req_type;
  logic [COORD_BITS-1:0] x_coord;
  logic [COORD_BITS-1:0] y_coord;
  logic [PIX_W-1:0]      pixel;
  logic [IDX_W-1:0]      margin_index;
  logic [COORD_BITS-1:0] margin_value;

  modport source (
    output valid, req_type, x_coord, y_coord, pixel, margin_index, margin_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, x_coord, y_coord, pixel, margin_index, margin_value,
    output ready
  );
endinterface

interface mrma_out_if;
  import mrma_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [IDX_W-1:0]      region;
  logic [CNT_W-1:0]      pixel_count;
  logic [XY_W-1:0]       x_sum;
  logic [XY_W-1:0]       y_sum;
  logic [IS_W-1:0]       intensity_sum;
  logic [PIX_W-1:0]      peak_intensity;
  logic [LOW_W-1:0]      x_low;
  logic [COORD_BITS-1:0] x_high;
  logic [LOW_W-1:0]      y_low;
  logic [COORD_BITS-1:0] y_high;
  logic                  last;

  modport source (
    output valid, region, pixel_count, x_sum, y_sum, intensity_sum, peak_intensity,
           x_low, x_high, y_low, y_high, last,
    input  ready
  );
  modport sink (
    input  valid, region, pixel_count, x_sum, y_sum, intensity_sum, peak_intensity,
           x_low, x_high, y_low, y_high, last,
    output ready
  );
endinterface

// ===== sv/marker_region_moment_accumulator_top.sv =====
// Top level of the marker region moment accumulator: entry stage, cell chain and result register.
//
// Every request word travels down a chain of 2*REGIONS_PER_ROW region cells, one cell per
// clock, and a new word is taken every clock, unless the chain is held. A pixel above the
// threshold is claimed by the first cell of its row whose margin lies below its y; margin
// writes and clears act on the cells as they pass. A readout word collects each region's
// statistics as it passes that region's cell, so its 2*REGIONS_PER_ROW results (18 by default)
// leave one per clock in region order via the result register. One readout at a time travels
// the chain: a second readout is held until the first reaches the last cell, while other
// words keep flowing. When a result waits at the output and is not taken, the whole chain
// holds. No clearing pass is needed after reset; statistics clear as a clear word passes.
module marker_region_moment_accumulator_top #(
  parameter int REGIONS_PER_ROW = mrma_pkg::REGIONS_PER_ROW_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  mrma_in_if.sink                       in_ch,
  mrma_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mrma_pkg::PADDR_W-1:0]  paddr,
  input  logic [mrma_pkg::PDATA_W-1:0]  pwdata,
  output logic [mrma_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import mrma_pkg::*;

  localparam int NREG = 2 * REGIONS_PER_ROW;

  cfg_t        cfg;
  item_t       stg_r    [NREG];
  item_t       stg0_nxt;
  item_t       cell_out [NREG];
  stat_t       stat_w   [NREG];
  item_t       tail;
  logic [NREG-1:0] tok_vec;
  logic        rd_busy;
  logic        adv;
  logic        in_ready;
  logic        in_acc;
  logic        out_valid_r;
  out_word_t   out_r;
  out_word_t   out_nxt;

  mrma_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The chain moves whenever the result register is free or being emptied.
  assign adv      = !out_valid_r || out_ch.ready;
  assign rd_busy  = |tok_vec[NREG-2:0];
  assign in_ready = adv && !(rd_busy && (req_t'(in_ch.req_type) == REQ_READ));
  assign in_acc   = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  // Entry word: threshold and row choice are settled here once.
  always_comb begin
    stg0_nxt.valid     = in_acc;
    stg0_nxt.req       = req_t'(in_ch.req_type);
    stg0_nxt.x         = in_ch.x_coord;
    stg0_nxt.y         = in_ch.y_coord;
    stg0_nxt.pix       = in_ch.pixel;
    stg0_nxt.keep      = in_ch.pixel > cfg.threshold;
    stg0_nxt.first_row = in_ch.x_coord > cfg.separator;
    stg0_nxt.done      = 1'b0;
    stg0_nxt.midx      = in_ch.margin_index;
    stg0_nxt.mval      = in_ch.margin_value;
  end

  // Stage registers between the cells.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NREG; i++) begin
        stg_r[i] <= '0;
      end
    end else if (adv) begin
      stg_r[0] <= stg0_nxt;
      for (int i = 1; i < NREG; i++) begin
        stg_r[i] <= cell_out[i-1];
      end
    end
  end

  // The chain of region cells.
  for (genvar g = 0; g < NREG; g++) begin : g_cell
    assign tok_vec[g] = stg_r[g].valid && (stg_r[g].req == REQ_READ);

    mrma_cell #(
      .CELL_IDX        (g),
      .REGIONS_PER_ROW (REGIONS_PER_ROW)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .adv          (adv),
      .frame_width  (cfg.frame_width),
      .frame_height (cfg.frame_height),
      .item_in      (stg_r[g]),
      .item_out     (cell_out[g]),
      .stat         (stat_w[g])
    );
  end

  assign tail = cell_out[NREG-1];

  // Pick the statistics of the cell that holds the readout word.
  always_comb begin
    out_nxt = '0;
    for (int i = 0; i < NREG; i++) begin
      if (tok_vec[i]) begin
        out_nxt.region = IDX_W'(i);
        out_nxt.st     = stat_w[i];
      end
    end
    out_nxt.last = tok_vec[NREG-1];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= |tok_vec;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.region         = out_r.region;
  assign out_ch.pixel_count    = out_r.st.cnt;
  assign out_ch.x_sum          = out_r.st.xsum;
  assign out_ch.y_sum          = out_r.st.ysum;
  assign out_ch.intensity_sum  = out_r.st.isum;
  assign out_ch.peak_intensity = out_r.st.peak;
  assign out_ch.x_low          = out_r.st.xlo;
  assign out_ch.x_high         = out_r.st.xhi;
  assign out_ch.y_low          = out_r.st.ylo;
  assign out_ch.y_high         = out_r.st.yhi;
  assign out_ch.last           = out_r.last;

  // At most one readout word is in the chain at any time.
  a_one_readout: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vec))
    else $error("more than one readout word in the cell chain");

  // A readout word leaving the last cell leaves the final result in the output register.
  a_tail_last: assert property (@(posedge clk) disable iff (!rst_n)
    adv && tail.valid && (tail.req == REQ_READ) |=> out_valid_r && out_r.last)
    else $error("readout left the chain without a final result word");

  // A held output freezes the chain.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(tok_vec))
    else $error("cell chain moved while the output was stalled");

  // An accepted readout enters the first cell.
  a_read_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (req_t'(in_ch.req_type) == REQ_READ) |=> tok_vec[0])
    else $error("accepted readout word did not enter the chain");

endmodule

// ===== sv/mrma_cfg.sv =====
// Configuration registers behind the APB-style port.
module mrma_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mrma_pkg::PADDR_W-1:0]  paddr,
  input  logic [mrma_pkg::PDATA_W-1:0]  pwdata,
  output logic [mrma_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output mrma_pkg::cfg_t                cfg
);
  import mrma_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  cfg_idx_t widx;

  assign widx   = cfg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Register write decode.
  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      case (widx)
        CFG_THRESHOLD: cfg_nxt.threshold    = pwdata[PIX_W-1:0];
        CFG_SEPARATOR: cfg_nxt.separator    = pwdata[COORD_BITS-1:0];
        CFG_FRAME_W:   cfg_nxt.frame_width  = pwdata[LOW_W-1:0];
        CFG_FRAME_H:   cfg_nxt.frame_height = pwdata[LOW_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold    <= THRESHOLD_RST;
      cfg_r.separator    <= SEPARATOR_RST;
      cfg_r.frame_width  <= FRAME_RST;
      cfg_r.frame_height <= FRAME_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Register read mux.
  always_comb begin
    case (widx)
      CFG_THRESHOLD: prdata = PDATA_W'(cfg_r.threshold);
      CFG_SEPARATOR: prdata = PDATA_W'(cfg_r.separator);
      CFG_FRAME_W:   prdata = PDATA_W'(cfg_r.frame_width);
      CFG_FRAME_H:   prdata = PDATA_W'(cfg_r.frame_height);
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== sv/mrma_cell.sv =====
// One region cell: holds the margin and statistics of a region and passes words on.
module mrma_cell #(
  parameter int CELL_IDX        = 0,
  parameter int REGIONS_PER_ROW = mrma_pkg::REGIONS_PER_ROW_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic [mrma_pkg::LOW_W-1:0]   frame_width,
  input  logic [mrma_pkg::LOW_W-1:0]   frame_height,
  input  mrma_pkg::item_t              item_in,
  output mrma_pkg::item_t              item_out,
  output mrma_pkg::stat_t              stat
);
  import mrma_pkg::*;

  localparam logic             IN_FIRST_ROW = (CELL_IDX < REGIONS_PER_ROW);
  localparam logic [IDX_W-1:0] MY_IDX       = IDX_W'(CELL_IDX);

  logic [COORD_BITS-1:0] margin_r;
  stat_t                 stat_r;
  stat_t                 stat_nxt;
  stat_t                 stat_rst;
  stat_t                 stat_clr;
  logic                  hit;
  logic                  wr;
  logic                  clr;
  logic [CNT_W:0]        cnt_sum;
  logic [XY_W:0]         xs_sum;
  logic [XY_W:0]         ys_sum;
  logic [IS_W:0]         is_sum;
  logic [LOW_W-1:0]      x_ext;
  logic [LOW_W-1:0]      y_ext;

  // A kept pixel lands here if no earlier cell took it, the row fits and y is past the margin.
  assign hit = item_in.valid && (item_in.req == REQ_PIXEL) && item_in.keep && !item_in.done
               && (item_in.first_row == IN_FIRST_ROW) && (item_in.y > margin_r);
  assign wr  = item_in.valid && (item_in.req == REQ_MARGIN) && (item_in.midx == MY_IDX);
  assign clr = item_in.valid && (item_in.req == REQ_CLEAR);

  // Hand the word to the next cell, marked as taken once a region owns it.
  always_comb begin
    item_out      = item_in;
    item_out.done = item_in.done | hit;
  end

  // Empty statistics after reset and after a clear word.
  always_comb begin
    stat_rst     = '0;
    stat_rst.xlo = FRAME_RST;
    stat_rst.ylo = FRAME_RST;
    stat_clr     = '0;
    stat_clr.xlo = frame_width;
    stat_clr.ylo = frame_height;
  end

  // Saturating sums, peak and bounding box update.
  always_comb begin
    x_ext   = LOW_W'(item_in.x);
    y_ext   = LOW_W'(item_in.y);
    cnt_sum = {1'b0, stat_r.cnt} + (CNT_W+1)'(1);
    xs_sum  = {1'b0, stat_r.xsum} + (XY_W+1)'(item_in.x);
    ys_sum  = {1'b0, stat_r.ysum} + (XY_W+1)'(item_in.y);
    is_sum  = {1'b0, stat_r.isum} + (IS_W+1)'(item_in.pix);

    stat_nxt      = stat_r;
    stat_nxt.cnt  = cnt_sum[CNT_W] ? {CNT_W{1'b1}} : cnt_sum[CNT_W-1:0];
    stat_nxt.xsum = xs_sum[XY_W] ? {XY_W{1'b1}} : xs_sum[XY_W-1:0];
    stat_nxt.ysum = ys_sum[XY_W] ? {XY_W{1'b1}} : ys_sum[XY_W-1:0];
    stat_nxt.isum = is_sum[IS_W] ? {IS_W{1'b1}} : is_sum[IS_W-1:0];
    if (item_in.pix > stat_r.peak) stat_nxt.peak = item_in.pix;
    if (x_ext < stat_r.xlo)        stat_nxt.xlo  = x_ext;
    if (item_in.x > stat_r.xhi)    stat_nxt.xhi  = item_in.x;
    if (y_ext < stat_r.ylo)        stat_nxt.ylo  = y_ext;
    if (item_in.y > stat_r.yhi)    stat_nxt.yhi  = item_in.y;
  end

  // Margin and statistics storage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= '0;
      stat_r   <= stat_rst;
    end else if (adv) begin
      if (wr) begin
        margin_r <= item_in.mval;
      end
      if (clr) begin
        stat_r <= stat_clr;
      end else if (hit) begin
        stat_r <= stat_nxt;
      end
    end
  end

  assign stat = stat_r;

endmodule
